@@ src/crg_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Credit gate package
// Shared codes, field widths and the types that pass between the gate's units.
// ----------------------------------------------------------------------------
package crg_pkg;

   localparam int OP_W        = 3;
   localparam int KIND_W      = 2;
   localparam int ST_W        = 3;
   localparam int COUNT_W     = 8;
   localparam int LIMIT_W     = 32;
   localparam int BYTES_W     = 64;
   localparam int PIECE_W     = 32;
   localparam int OFFSET_W    = 32;
   localparam int LENGTH_W    = 24;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 32;

   // Request transaction: piece, offset, length from the lowest bit up.
   localparam int REQ_DATA_W = PIECE_W + OFFSET_W + LENGTH_W;
   // Result transaction: piece, offset, length, status, outstanding, pad.
   localparam int RSP_STATUS_LSB = PIECE_W + OFFSET_W + LENGTH_W;
   localparam int RSP_COUNT_LSB  = RSP_STATUS_LSB + ST_W;
   localparam int RSP_PAD_W      = 5;
   localparam int RSP_DATA_W     = RSP_COUNT_LSB + COUNT_W + RSP_PAD_W;

   localparam logic [OP_W-1:0] OP_REQUEST  = 3'd0;
   localparam logic [OP_W-1:0] OP_COMPLETE = 3'd1;
   localparam logic [OP_W-1:0] OP_REJECT   = 3'd2;
   localparam logic [OP_W-1:0] OP_CANCEL   = 3'd3;
   localparam logic [OP_W-1:0] OP_CHOKE    = 3'd4;
   localparam logic [OP_W-1:0] OP_UNCHOKE  = 3'd5;

   localparam logic [KIND_W-1:0] KIND_REQUEST = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CANCEL  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_STATUS  = 2'd2;

   localparam logic [ST_W-1:0] ST_DONE     = 3'd0;
   localparam logic [ST_W-1:0] ST_QUEUED   = 3'd1;
   localparam logic [ST_W-1:0] ST_DROPPED  = 3'd2;
   localparam logic [ST_W-1:0] ST_REMOVED  = 3'd3;
   localparam logic [ST_W-1:0] ST_RELEASED = 3'd4;

   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_OUTSTANDING = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BYTE_LIMIT      = 4'd1;

   localparam logic [COUNT_W-1:0] MAX_OUT_RESET    = 8'd16;
   localparam logic [LIMIT_W-1:0] BYTE_LIMIT_RESET = 32'd1048576;

   typedef struct packed {
      logic [PIECE_W-1:0]  piece;
      logic [OFFSET_W-1:0] offset;
      logic [LENGTH_W-1:0] size;
   } entry_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } qctl_type;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [PIECE_W-1:0]  piece;
      logic [OFFSET_W-1:0] offset;
      logic [LENGTH_W-1:0] length;
      logic [ST_W-1:0]     status;
      logic [COUNT_W-1:0]  outstanding;
      logic                last;
   } result_type;

endpackage
`default_nettype wire

@@ src/crg_addsub.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Credit gate adder/subtractor
// The one 64-bit add/subtract unit that all byte accounting goes through.
// ----------------------------------------------------------------------------
module crg_addsub (
   input  logic [crg_pkg::BYTES_W-1:0] alu_a,
   input  logic [crg_pkg::BYTES_W-1:0] alu_b,
   input  logic                        alu_sub,
   output logic [crg_pkg::BYTES_W-1:0] alu_sum,
   output logic                        alu_carry
);
   import crg_pkg::*;

   logic [BYTES_W-1:0] b_op;

   // On a subtract, a set carry means no borrow, so a >= b.
   assign b_op = alu_sub ? ~alu_b : alu_b;
   assign {alu_carry, alu_sum} = {1'b0, alu_a} + {1'b0, b_op} + {{BYTES_W{1'b0}}, alu_sub};

endmodule
`default_nettype wire

@@ src/crg_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Credit gate request queue
// Circular store of waiting requests: one write port, one registered read port.
// ----------------------------------------------------------------------------
module crg_queue #(
   parameter int QUEUE_DEPTH = 32,
   localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
   input  logic               clock,
   input  crg_pkg::qctl_type  qctl,
   input  logic [QW-1:0]      wr_addr,
   input  crg_pkg::entry_type wr_data,
   input  logic [QW-1:0]      rd_addr,
   output crg_pkg::entry_type rd_data
);
   import crg_pkg::*;

   entry_type mem [QUEUE_DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (qctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (qctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ src/crg_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Credit gate sequencer
// Steps one transaction through accounting, queue search, flush and output.
// ----------------------------------------------------------------------------
module crg_ctrl #(
   parameter int QUEUE_DEPTH = 32,
   localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
   localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [crg_pkg::OP_W-1:0]       opcode,
   input  crg_pkg::entry_type             item,
   input  logic [crg_pkg::COUNT_W-1:0]    max_outstanding,
   input  logic [crg_pkg::LIMIT_W-1:0]    byte_limit,
   input  logic                           push_ok,
   output logic                           idle,
   output logic                           push,
   output crg_pkg::result_type            result,
   output crg_pkg::qctl_type              qctl,
   output logic [QW-1:0]                  wr_addr,
   output crg_pkg::entry_type             wr_data,
   output logic [QW-1:0]                  rd_addr,
   input  crg_pkg::entry_type             rd_data,
   output logic [crg_pkg::BYTES_W-1:0]    alu_a,
   output logic [crg_pkg::BYTES_W-1:0]    alu_b,
   output logic                           alu_sub,
   input  logic [crg_pkg::BYTES_W-1:0]    alu_sum,
   input  logic                           alu_carry
);
   import crg_pkg::*;

   localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
   localparam logic [CW-1:0] ONE_C   = CW'(1);

   localparam logic [4:0] S_IDLE    = 5'd0;
   localparam logic [4:0] S_START   = 5'd1;
   localparam logic [4:0] S_RQ_INF  = 5'd2;
   localparam logic [4:0] S_RQ_LIM  = 5'd3;
   localparam logic [4:0] S_RQ_ADD  = 5'd4;
   localparam logic [4:0] S_CP_INF  = 5'd5;
   localparam logic [4:0] S_CP_CMP  = 5'd6;
   localparam logic [4:0] S_CP_ADD  = 5'd7;
   localparam logic [4:0] S_DEB     = 5'd8;
   localparam logic [4:0] S_REL     = 5'd9;
   localparam logic [4:0] S_SR_RD   = 5'd10;
   localparam logic [4:0] S_SR_CMP  = 5'd11;
   localparam logic [4:0] S_RM_RD   = 5'd12;
   localparam logic [4:0] S_RM_WR   = 5'd13;
   localparam logic [4:0] S_FL_CHK  = 5'd14;
   localparam logic [4:0] S_FL_INF  = 5'd15;
   localparam logic [4:0] S_FL_LIM  = 5'd16;
   localparam logic [4:0] S_FL_ADD  = 5'd17;
   localparam logic [4:0] S_EMIT    = 5'd18;
   localparam logic [4:0] S_EM_PUSH = 5'd19;
   localparam logic [4:0] S_ECHO    = 5'd20;
   localparam logic [4:0] S_STATUS  = 5'd21;

   // Physical slot of a logical queue position, counted from a base slot.
   function automatic logic [QW-1:0] wrap_pos(input logic [QW-1:0] base,
                                              input logic [CW-1:0] off);
      logic [CW:0] s;
      s = {{(CW + 1 - QW){1'b0}}, base} + {1'b0, off};
      if (s >= {1'b0, DEPTH_C}) begin
         s = s - {1'b0, DEPTH_C};
      end
      return s[QW-1:0];
   endfunction

   logic [4:0]         state_ff, state_in;
   logic [OP_W-1:0]    op_ff, op_in;
   entry_type          item_ff, item_in;
   logic               choked_ff, choked_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [BYTES_W-1:0] req_bytes_ff, req_bytes_in;
   logic [BYTES_W-1:0] rcv_bytes_ff, rcv_bytes_in;
   logic [BYTES_W-1:0] inflight_ff, inflight_in;
   logic               over_ff, over_in;
   logic [QW-1:0]      head_ff, head_in;
   logic [CW-1:0]      fill_ff, fill_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [CW-1:0]      nflush_ff, nflush_in;
   logic [QW-1:0]      emit_ptr_ff, emit_ptr_in;
   logic               echo_ff, echo_in;
   logic [KIND_W-1:0]  echo_kind_ff, echo_kind_in;
   logic [ST_W-1:0]    status_ff, status_in;

   logic [BYTES_W-1:0] len64;
   logic [CW-1:0]      idx_inc;
   logic [COUNT_W-1:0] count_inc;
   logic               at_limit;

   assign len64     = {{(BYTES_W - LENGTH_W){1'b0}}, item_ff.size};
   assign idx_inc   = idx_ff + ONE_C;
   assign count_inc = (count_ff != {COUNT_W{1'b1}}) ? count_ff + 8'd1 : count_ff;
   // Valid in the limit states, where the unit computes inflight - limit.
   assign at_limit  = alu_carry || (count_ff >= max_outstanding);
   assign idle      = (state_ff == S_IDLE);

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      item_in      = item_ff;
      choked_in    = choked_ff;
      count_in     = count_ff;
      req_bytes_in = req_bytes_ff;
      rcv_bytes_in = rcv_bytes_ff;
      inflight_in  = inflight_ff;
      over_in      = over_ff;
      head_in      = head_ff;
      fill_in      = fill_ff;
      idx_in       = idx_ff;
      nflush_in    = nflush_ff;
      emit_ptr_in  = emit_ptr_ff;
      echo_in      = echo_ff;
      echo_kind_in = echo_kind_ff;
      status_in    = status_ff;

      qctl    = '0;
      wr_addr = head_ff;
      wr_data = item_ff;
      rd_addr = head_ff;
      push    = 1'b0;
      result  = '0;
      result.outstanding = count_ff;
      alu_a   = '0;
      alu_b   = '0;
      alu_sub = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in    = opcode;
               item_in  = item;
               state_in = S_START;
            end
         end
         S_START: begin
            nflush_in = '0;
            echo_in   = 1'b0;
            status_in = ST_DONE;
            idx_in    = '0;
            case (op_ff)
               OP_REQUEST:  state_in = S_RQ_INF;
               OP_COMPLETE: state_in = S_CP_INF;
               OP_REJECT:   state_in = S_DEB;
               OP_CANCEL:   state_in = S_SR_RD;
               OP_CHOKE: begin
                  choked_in    = 1'b1;
                  fill_in      = '0;
                  count_in     = '0;
                  req_bytes_in = '0;
                  rcv_bytes_in = '0;
                  state_in     = S_STATUS;
               end
               OP_UNCHOKE: begin
                  choked_in = 1'b0;
                  state_in  = S_FL_CHK;
               end
               default: state_in = S_STATUS;
            endcase
         end
         S_RQ_INF, S_CP_INF: begin
            alu_a       = req_bytes_ff;
            alu_b       = rcv_bytes_ff;
            alu_sub     = 1'b1;
            inflight_in = alu_carry ? alu_sum : '0;
            over_in     = ~alu_carry;
            state_in    = (state_ff == S_RQ_INF) ? S_RQ_LIM : S_CP_CMP;
         end
         S_RQ_LIM: begin
            alu_a   = inflight_ff;
            alu_b   = {{(BYTES_W - LIMIT_W){1'b0}}, byte_limit};
            alu_sub = 1'b1;
            if (at_limit) begin
               if (fill_ff != DEPTH_C) begin
                  qctl.wr_en = 1'b1;
                  wr_addr    = wrap_pos(head_ff, fill_ff);
                  fill_in    = fill_ff + ONE_C;
                  status_in  = ST_QUEUED;
               end else begin
                  status_in = ST_DROPPED;
               end
               state_in = S_STATUS;
            end else begin
               count_in = count_inc;
               state_in = S_RQ_ADD;
            end
         end
         S_RQ_ADD: begin
            alu_a        = req_bytes_ff;
            alu_b        = len64;
            req_bytes_in = alu_sum;
            echo_in      = 1'b1;
            echo_kind_in = KIND_REQUEST;
            state_in     = S_EMIT;
         end
         S_CP_CMP: begin
            // Credit is clamped when received already exceeds requested or
            // the completion is larger than what is in flight.
            alu_a   = inflight_ff;
            alu_b   = len64;
            alu_sub = 1'b1;
            if (over_ff || !alu_carry) begin
               rcv_bytes_in = req_bytes_ff;
               state_in     = S_REL;
            end else begin
               state_in = S_CP_ADD;
            end
         end
         S_CP_ADD: begin
            alu_a        = rcv_bytes_ff;
            alu_b        = len64;
            rcv_bytes_in = alu_sum;
            state_in     = S_REL;
         end
         S_DEB: begin
            alu_a        = req_bytes_ff;
            alu_b        = len64;
            alu_sub      = 1'b1;
            req_bytes_in = alu_carry ? alu_sum : '0;
            state_in     = S_REL;
         end
         S_REL: begin
            if (count_ff != '0) begin
               count_in = count_ff - 8'd1;
            end
            state_in = S_FL_CHK;
         end
         S_SR_RD: begin
            if (idx_ff == fill_ff) begin
               echo_in      = 1'b1;
               echo_kind_in = KIND_CANCEL;
               status_in    = ST_RELEASED;
               state_in     = S_DEB;
            end else begin
               qctl.rd_en = 1'b1;
               rd_addr    = wrap_pos(head_ff, idx_ff);
               state_in   = S_SR_CMP;
            end
         end
         S_SR_CMP: begin
            if (rd_data == item_ff) begin
               status_in = ST_REMOVED;
               state_in  = S_RM_RD;
            end else begin
               idx_in   = idx_inc;
               state_in = S_SR_RD;
            end
         end
         S_RM_RD: begin
            if (idx_inc == fill_ff) begin
               fill_in  = fill_ff - ONE_C;
               state_in = S_FL_CHK;
            end else begin
               qctl.rd_en = 1'b1;
               rd_addr    = wrap_pos(head_ff, idx_inc);
               state_in   = S_RM_WR;
            end
         end
         S_RM_WR: begin
            qctl.wr_en = 1'b1;
            wr_addr    = wrap_pos(head_ff, idx_ff);
            wr_data    = rd_data;
            idx_in     = idx_inc;
            state_in   = S_RM_RD;
         end
         S_FL_CHK: begin
            // Flushed entries stay in place behind the head until they are
            // read back out for the result stream.
            emit_ptr_in = head_ff;
            state_in    = choked_ff ? S_EMIT : S_FL_INF;
         end
         S_FL_INF: begin
            if (fill_ff == '0) begin
               state_in = S_EMIT;
            end else begin
               alu_a       = req_bytes_ff;
               alu_b       = rcv_bytes_ff;
               alu_sub     = 1'b1;
               inflight_in = alu_carry ? alu_sum : '0;
               qctl.rd_en  = 1'b1;
               rd_addr     = head_ff;
               state_in    = S_FL_LIM;
            end
         end
         S_FL_LIM: begin
            alu_a   = inflight_ff;
            alu_b   = {{(BYTES_W - LIMIT_W){1'b0}}, byte_limit};
            alu_sub = 1'b1;
            if (at_limit) begin
               state_in = S_EMIT;
            end else begin
               count_in = count_inc;
               state_in = S_FL_ADD;
            end
         end
         S_FL_ADD: begin
            alu_a        = req_bytes_ff;
            alu_b        = {{(BYTES_W - LENGTH_W){1'b0}}, rd_data.size};
            req_bytes_in = alu_sum;
            head_in      = wrap_pos(head_ff, ONE_C);
            fill_in      = fill_ff - ONE_C;
            nflush_in    = nflush_ff + ONE_C;
            state_in     = S_FL_INF;
         end
         S_EMIT: begin
            if (nflush_ff != '0) begin
               qctl.rd_en = 1'b1;
               rd_addr    = emit_ptr_ff;
               state_in   = S_EM_PUSH;
            end else begin
               state_in = echo_ff ? S_ECHO : S_STATUS;
            end
         end
         S_EM_PUSH: begin
            result.kind   = KIND_REQUEST;
            result.piece  = rd_data.piece;
            result.offset = rd_data.offset;
            result.length = rd_data.size;
            if (push_ok) begin
               push        = 1'b1;
               emit_ptr_in = wrap_pos(emit_ptr_ff, ONE_C);
               nflush_in   = nflush_ff - ONE_C;
               state_in    = S_EMIT;
            end
         end
         S_ECHO: begin
            result.kind   = echo_kind_ff;
            result.piece  = item_ff.piece;
            result.offset = item_ff.offset;
            result.length = item_ff.size;
            if (push_ok) begin
               push     = 1'b1;
               state_in = S_STATUS;
            end
         end
         S_STATUS: begin
            result.kind   = KIND_STATUS;
            result.status = status_ff;
            result.last   = 1'b1;
            if (push_ok) begin
               push     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         choked_ff    <= 1'b1;
         count_ff     <= '0;
         req_bytes_ff <= '0;
         rcv_bytes_ff <= '0;
         head_ff      <= '0;
         fill_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         choked_ff    <= choked_in;
         count_ff     <= count_in;
         req_bytes_ff <= req_bytes_in;
         rcv_bytes_ff <= rcv_bytes_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      item_ff      <= item_in;
      inflight_ff  <= inflight_in;
      over_ff      <= over_in;
      idx_ff       <= idx_in;
      nflush_ff    <= nflush_in;
      emit_ptr_ff  <= emit_ptr_in;
      echo_ff      <= echo_in;
      echo_kind_ff <= echo_kind_in;
      status_ff    <= status_in;
   end

endmodule
`default_nettype wire

@@ src/request_pipeline_credit_gate.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Request pipeline credit gate
// Limits block requests by outstanding count and in-flight bytes.
// ----------------------------------------------------------------------------
// Commands enter on the req_ stream (opcode in tuser), results leave on the
// rsp_ stream: wire requests and cancels first, then one status transaction
// with tlast set. The csr_ channel writes the two limits and is always ready.
// One command is processed at a time; req_tready is low while it runs.
// Each command is sequenced through one shared 64-bit add/subtract unit and
// the single read port of the queue memory. A choke or an unknown opcode only
// returns a status; a request is issued, queued or dropped. A completion
// (clamped or not), a reject and an unchoke are followed, unless choked, by a
// flush of queue entries that stops at a limit or when the queue is empty; a
// cancel searches the queue entry by entry, shifts later entries down on
// removal and then flushes the same way.
// Reset empties the queue, clears all accounting, restores the default limits
// and starts in the choked state. A stalled receiver holds the result in the
// output register; the sequencer waits there, and a new command is accepted
// once the status transaction has moved into that register.
// ----------------------------------------------------------------------------
module request_pipeline_credit_gate #(
   parameter int QUEUE_DEPTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // piece [31:0], begin offset [63:32], length [87:64]
   input  logic [crg_pkg::REQ_DATA_W-1:0]        req_tdata,
   // opcode [2:0]
   input  logic [crg_pkg::OP_W-1:0]              req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // out_index [31:0], out_begin [63:32], out_length [87:64], status [90:88],
   // outstanding_now [98:91], zero pad [103:99]
   output logic [crg_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   // kind [1:0]
   output logic [crg_pkg::KIND_W-1:0]            rsp_tuser,
   output logic                                  rsp_tlast,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [crg_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [crg_pkg::CSR_DATA_W-1:0]        csr_data
);
   import crg_pkg::*;

   localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   logic [COUNT_W-1:0] max_out_ff;
   logic [LIMIT_W-1:0] byte_limit_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_item_ff, rsp_item_in;

   entry_type          req_item;
   logic               idle;
   logic               push;
   logic               push_ok;
   result_type         result;
   qctl_type           qctl;
   logic [QW-1:0]      wr_addr;
   logic [QW-1:0]      rd_addr;
   entry_type          wr_data;
   entry_type          rd_data;
   logic [BYTES_W-1:0] alu_a;
   logic [BYTES_W-1:0] alu_b;
   logic               alu_sub;
   logic [BYTES_W-1:0] alu_sum;
   logic               alu_carry;

   always_comb begin
      req_item.piece  = req_tdata[PIECE_W-1:0];
      req_item.offset = req_tdata[PIECE_W +: OFFSET_W];
      req_item.size   = req_tdata[PIECE_W + OFFSET_W +: LENGTH_W];
   end

   assign req_tready = idle;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_out_ff    <= MAX_OUT_RESET;
         byte_limit_ff <= BYTE_LIMIT_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_MAX_OUTSTANDING: max_out_ff    <= csr_data[COUNT_W-1:0];
            CSR_BYTE_LIMIT:      byte_limit_ff <= csr_data[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   crg_addsub u_addsub (
      .alu_a     (alu_a),
      .alu_b     (alu_b),
      .alu_sub   (alu_sub),
      .alu_sum   (alu_sum),
      .alu_carry (alu_carry)
   );

   crg_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .qctl    (qctl),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   crg_ctrl #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (req_tvalid & req_tready),
      .opcode          (req_tuser),
      .item            (req_item),
      .max_outstanding (max_out_ff),
      .byte_limit      (byte_limit_ff),
      .push_ok         (push_ok),
      .idle            (idle),
      .push            (push),
      .result          (result),
      .qctl            (qctl),
      .wr_addr         (wr_addr),
      .wr_data         (wr_data),
      .rd_addr         (rd_addr),
      .rd_data         (rd_data),
      .alu_a           (alu_a),
      .alu_b           (alu_b),
      .alu_sub         (alu_sub),
      .alu_sum         (alu_sum),
      .alu_carry       (alu_carry)
   );

   // Output register: a new result may load in the same cycle the held one
   // is taken.
   assign push_ok = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_item_in  = push ? result : rsp_item_ff;
      if (push) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_item_ff.kind;
   assign rsp_tlast  = rsp_item_ff.last;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_item_ff.outstanding, rsp_item_ff.status,
                        rsp_item_ff.length, rsp_item_ff.offset, rsp_item_ff.piece};

endmodule
`default_nettype wire

@@ src/crg_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Credit gate port checker
// Watches the gate's streams for ordering and framing of result transactions.
// ----------------------------------------------------------------------------
module crg_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [crg_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic [crg_pkg::KIND_W-1:0]     rsp_tuser,
   input  logic                           rsp_tlast
);
   import crg_pkg::*;

   // A stalled result holds still.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // The gate works on one command at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("command accepted while another is in progress");

   // Exactly the status transaction closes a command.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tuser == KIND_STATUS)))
      else $error("tlast does not match the status kind");

   // Wire transactions carry no status code.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != KIND_STATUS |-> rsp_tdata[RSP_STATUS_LSB +: ST_W] == ST_DONE)
      else $error("wire transaction with a status code");

endmodule

bind request_pipeline_credit_gate crg_checker u_crg_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire
